// ----- sv/elic_pkg.sv -----
// shared types and constants for the edge/level interrupt controller
// no dependencies; used by elic_cfg, elic_core and the top level

package elic_pkg;

    localparam int MAX_EXT_LINES_DEF = 16;
    localparam int INT_LINES         = 16;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_IDX_W         = 2;
    localparam int CNT_FIELD_W       = 5;

    localparam logic [15:0] INT_MASK           = 16'hffff;
    localparam logic [31:0] ENABLE_FORCED_ZERO = 32'h0000_7800;

    localparam logic [6:0] OFF_STATUS  = 7'h30;
    localparam logic [6:0] OFF_PENDING = 7'h34;
    localparam logic [6:0] OFF_ENABLE  = 7'h38;
    localparam logic [6:0] OFF_ACK     = 7'h3c;

    typedef enum logic [1:0] {
        OP_LINE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_MASK   = 2'd0,
        CFG_ACTIVE_HIGH = 2'd1,
        CFG_LINE_COUNT  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [4:0]  line_index;
        logic        line_level;
        logic [6:0]  reg_offset;
        logic [31:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_out;
    } out_item_t;

    // external line configuration as seen by the core
    typedef struct packed {
        logic [15:0]            edge_ext;
        logic [15:0]            high_ext;
        logic [CNT_FIELD_W-1:0] line_count;
    } cfg_t;

endpackage

// ----- sv/elic_cfg.sv -----
// configuration registers: external edge mask, polarity and line count
// depends on elic_pkg

module elic_cfg #(
    parameter int MAX_EXTERNAL_LINES = elic_pkg::MAX_EXT_LINES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [elic_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [elic_pkg::CFG_DATA_W-1:0] wr_data,
    output elic_pkg::cfg_t                  cfg
);

    localparam int CNT_W = $clog2(MAX_EXTERNAL_LINES + 1);

    logic [MAX_EXTERNAL_LINES-1:0] edge_reg;
    logic [MAX_EXTERNAL_LINES-1:0] high_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_clamped;

    // counts above the number of built lines act as the maximum
    always_comb
    begin
        if (wr_data[elic_pkg::CNT_FIELD_W-1:0] >
            elic_pkg::CNT_FIELD_W'(MAX_EXTERNAL_LINES))
        begin
            cnt_clamped = CNT_W'(MAX_EXTERNAL_LINES);
        end
        else
        begin
            cnt_clamped = wr_data[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg <= '0;
            high_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                elic_pkg::CFG_EDGE_MASK:   edge_reg <= wr_data[MAX_EXTERNAL_LINES-1:0];
                elic_pkg::CFG_ACTIVE_HIGH: high_reg <= wr_data[MAX_EXTERNAL_LINES-1:0];
                elic_pkg::CFG_LINE_COUNT:  cnt_reg  <= cnt_clamped;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.edge_ext   = 16'(edge_reg);
    assign cfg.high_ext   = 16'(high_reg);
    assign cfg.line_count = elic_pkg::CNT_FIELD_W'(cnt_reg);

endmodule

// ----- sv/elic_core.sv -----
// interrupt state (raw lines, status, enable, last ack) and per-item update
// depends on elic_pkg; driven by the top level's input stage

module elic_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  elic_pkg::in_item_t  item,
    input  elic_pkg::cfg_t      cfg,
    output elic_pkg::out_item_t result,
    output logic [31:0]         enable_bits
);

    logic [31:0] raw_reg,    raw_next;
    logic [31:0] status_reg, status_next;
    logic [31:0] enable_reg, enable_next;
    logic [31:0] ack_reg,    ack_next;

    logic [31:0] edge_full;
    logic [31:0] high_full;
    logic [31:0] present;
    logic [15:0] ext_present;
    logic        lvl_act;
    logic [31:0] rd;

    always_comb
    begin
        for (int j = 0; j < 16; j++)
        begin
            ext_present[j] = (elic_pkg::CNT_FIELD_W'(j) < cfg.line_count);
        end
    end

    assign edge_full = {cfg.edge_ext, elic_pkg::INT_MASK};
    assign high_full = {cfg.high_ext, elic_pkg::INT_MASK};
    assign present   = {ext_present, elic_pkg::INT_MASK};

    // polarity-corrected level of the addressed line
    assign lvl_act = item.line_level ^ ~high_full[item.line_index];

    always_comb
    begin
        raw_next    = raw_reg;
        status_next = status_reg;
        enable_next = enable_reg;
        ack_next    = ack_reg;
        rd          = '0;
        case (item.opcode)
            elic_pkg::OP_LINE:
            begin
                if (present[item.line_index])
                begin
                    raw_next[item.line_index] = lvl_act;
                    if (edge_full[item.line_index])
                    begin
                        status_next[item.line_index] = status_reg[item.line_index] |
                            (lvl_act & ~raw_reg[item.line_index]);
                    end
                    else
                    begin
                        status_next[item.line_index] = status_reg[item.line_index] | lvl_act;
                    end
                end
            end
            elic_pkg::OP_WRITE:
            begin
                if (item.reg_offset == elic_pkg::OFF_ENABLE)
                begin
                    enable_next = item.write_data & ~elic_pkg::ENABLE_FORCED_ZERO;
                end
                else if (item.reg_offset == elic_pkg::OFF_ACK)
                begin
                    ack_next = item.write_data;
                    // level lines still active come straight back
                    status_next = (status_reg & ~item.write_data) |
                                  (raw_reg & ~edge_full & present);
                end
            end
            elic_pkg::OP_READ:
            begin
                if (item.reg_offset == elic_pkg::OFF_STATUS)
                begin
                    rd = status_reg;
                end
                else if (item.reg_offset == elic_pkg::OFF_PENDING)
                begin
                    rd = status_reg & enable_reg;
                end
                else if (item.reg_offset == elic_pkg::OFF_ENABLE)
                begin
                    rd = enable_reg;
                end
                else if (item.reg_offset == elic_pkg::OFF_ACK)
                begin
                    rd = ack_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg    <= '0;
            status_reg <= '0;
            enable_reg <= '0;
            ack_reg    <= '0;
        end
        else if (fire)
        begin
            raw_reg    <= raw_next;
            status_reg <= status_next;
            enable_reg <= enable_next;
            ack_reg    <= ack_next;
        end
    end

    assign result.read_data = rd;
    assign result.irq_out   = |(status_next & enable_next);
    assign enable_bits      = enable_reg;

endmodule

// ----- sv/edge_level_interrupt_controller.sv -----
// top level: input register, interrupt core and result register
// depends on elic_pkg, elic_cfg and elic_core
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------
//   in      | into      | in_valid / in_stall  | in_data  (in_item_t)
//   out     | out of    | out_valid / out_stall| out_data (out_item_t)
//   cfg     | into      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item per clock while in_stall is low; each item is held in the input
// register, and its result is loaded into the result register as the item
// leaves the input register, and is held there until taken. the state update
// happens as the item leaves the input register.
// rst_n clears the valid flags, core state and config asynchronously. out_stall
// holds the result register; the input register keeps taking one more item
// behind it, and in_stall rises only when both registers are full.

module edge_level_interrupt_controller #(
    parameter int MAX_EXTERNAL_LINES = elic_pkg::MAX_EXT_LINES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  elic_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output elic_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [elic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [elic_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                s1_valid_reg, s1_valid_next;
    elic_pkg::in_item_t  s1_item_reg;
    logic                out_valid_reg, out_valid_next;
    elic_pkg::out_item_t out_item_reg;

    elic_pkg::cfg_t      cfg;
    elic_pkg::out_item_t core_result;
    logic [31:0]         enable_bits;
    logic                adv;
    logic                take;

    assign cfg_ready = 1'b1;

    elic_cfg #(
        .MAX_EXTERNAL_LINES(MAX_EXTERNAL_LINES)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    elic_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (adv),
        .item        (s1_item_reg),
        .cfg         (cfg),
        .result      (core_result),
        .enable_bits (enable_bits)
    );

    // input register moves on whenever the result register is free or draining
    assign adv      = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = s1_valid_reg & ~adv;
    assign take     = in_valid & ~in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg <= in_data;
        end
        if (adv)
        begin
            out_item_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // an empty input register never pushes back
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("in_stall raised with empty input register");

    // a taken result with nothing behind it leaves the output empty
    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !s1_valid_reg) |=> !out_valid)
        else $error("result repeated after transaction");

    // enable bits 11..14 are never stored
    a_enable_forced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (enable_bits & elic_pkg::ENABLE_FORCED_ZERO) == 32'h0)
        else $error("forced-zero enable bits set");

    // aims at a held input item moving on once the output frees up; in_stall implies out_stall, so it never fires
    a_stall_resolves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && !out_stall) |=> s1_valid_reg && out_valid)
        else $error("input register lost during stall");

endmodule

// ----- test/edge_level_interrupt_controller_tb.sv -----
// testbench for edge_level_interrupt_controller: directed and random line events and
// register accesses, checked against an in-bench prediction of status, enable and irq
// depends on elic_pkg and the edge_level_interrupt_controller RTL
`timescale 1ns / 100ps

module edge_level_interrupt_controller_tb;

    localparam int MAX_EXTERNAL_LINES = elic_pkg::MAX_EXT_LINES_DEF;
    localparam int WATCHDOG_LIMIT     = 5000;
    localparam int PHASE_ITEMS        = 84;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    elic_pkg::in_item_t              in_data   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    elic_pkg::out_item_t             out_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [elic_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [elic_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // predicted controller state and configuration
    logic [15:0] ext_edge;
    logic [15:0] ext_high;
    logic [4:0]  ext_count;
    logic [31:0] raw_lines;
    logic [31:0] status_reg;
    logic [31:0] enable_reg;
    logic [31:0] ack_word;

    elic_pkg::in_item_t  pending_items[$];
    elic_pkg::out_item_t expected_results[$];
    elic_pkg::out_item_t exp_r;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;

    edge_level_interrupt_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned present_lines();
        return elic_pkg::INT_LINES +
               ((ext_count > MAX_EXTERNAL_LINES) ? MAX_EXTERNAL_LINES : ext_count);
    endfunction

    function automatic elic_pkg::out_item_t predict_irq_result(elic_pkg::in_item_t it);
        logic [31:0] edge_lines;
        logic [31:0] high_lines;
        logic [31:0] present;
        logic [31:0] bit_m;
        logic [31:0] prev_v;
        logic [31:0] now_v;
        int unsigned lines;
        elic_pkg::out_item_t r;
        edge_lines = {ext_edge, elic_pkg::INT_MASK};
        high_lines = {ext_high, elic_pkg::INT_MASK};
        lines      = present_lines();
        present    = (lines >= 32) ? 32'hffff_ffff : ((32'd1 << lines) - 32'd1);
        r          = '0;
        case (it.opcode)
            elic_pkg::OP_LINE:
            begin
                // events on absent lines leave everything alone
                if (it.line_index < lines)
                begin
                    bit_m  = 32'd1 << it.line_index;
                    prev_v = raw_lines & bit_m;
                    now_v  = it.line_level ? bit_m : 32'd0;
                    if ((high_lines & bit_m) == 32'd0)
                        now_v = now_v ^ bit_m;
                    raw_lines = (raw_lines & ~bit_m) | now_v;
                    if ((edge_lines & bit_m) != 32'd0)
                        status_reg = status_reg | (now_v & ~prev_v);
                    else
                        status_reg = status_reg | now_v;
                end
            end
            elic_pkg::OP_WRITE:
            begin
                if (it.reg_offset == elic_pkg::OFF_ENABLE)
                    enable_reg = it.write_data & ~elic_pkg::ENABLE_FORCED_ZERO;
                else if (it.reg_offset == elic_pkg::OFF_ACK)
                begin
                    ack_word   = it.write_data;
                    status_reg = status_reg & ~it.write_data;
                    // level lines still active come straight back
                    status_reg = status_reg | (raw_lines & ~edge_lines & present);
                end
            end
            elic_pkg::OP_READ:
            begin
                if (it.reg_offset == elic_pkg::OFF_STATUS)
                    r.read_data = status_reg;
                else if (it.reg_offset == elic_pkg::OFF_PENDING)
                    r.read_data = status_reg & enable_reg;
                else if (it.reg_offset == elic_pkg::OFF_ENABLE)
                    r.read_data = enable_reg;
                else if (it.reg_offset == elic_pkg::OFF_ACK)
                    r.read_data = ack_word;
            end
            default: ;
        endcase
        r.irq_out = ((status_reg & enable_reg) != 32'd0);
        return r;
    endfunction

    function automatic logic [6:0] random_offset();
        case ($urandom_range(4))
            0: return elic_pkg::OFF_STATUS;
            1: return elic_pkg::OFF_PENDING;
            2: return elic_pkg::OFF_ENABLE;
            3: return elic_pkg::OFF_ACK;
            default: return 7'($urandom);
        endcase
    endfunction

    function automatic elic_pkg::in_item_t random_irq_item();
        elic_pkg::in_item_t it;
        int unsigned        sel;
        it.opcode     = elic_pkg::OP_NOP;
        it.line_index = 5'($urandom);
        it.line_level = 1'($urandom);
        it.reg_offset = 7'($urandom);
        it.write_data = $urandom;
        sel = $urandom_range(99);
        if (sel < 45)
        begin
            it.opcode = elic_pkg::OP_LINE;
            // mostly present lines, sometimes anything
            if ($urandom_range(4) != 0)
                it.line_index = 5'($urandom_range(present_lines() - 1, 0));
        end
        else if (sel < 65)
        begin
            it.opcode     = elic_pkg::OP_WRITE;
            it.reg_offset = random_offset();
            if ($urandom_range(2) == 0)
                it.write_data = it.write_data & $urandom & $urandom;
        end
        else if (sel < 95)
        begin
            it.opcode     = elic_pkg::OP_READ;
            it.reg_offset = random_offset();
        end
        return it;
    endfunction

    task automatic queue_line(input logic [4:0] idx, input logic lvl);
        pending_items.push_back('{elic_pkg::OP_LINE, idx, lvl, 7'($urandom), $urandom});
    endtask

    task automatic queue_write(input logic [6:0] off, input logic [31:0] wd);
        pending_items.push_back('{elic_pkg::OP_WRITE, 5'($urandom), 1'($urandom), off, wd});
    endtask

    task automatic queue_read(input logic [6:0] off);
        pending_items.push_back('{elic_pkg::OP_READ, 5'($urandom), 1'($urandom), off,
                                  $urandom});
    endtask

    // sampled at the falling edge so the driver and monitor have settled; returns at a
    // rising edge
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_config(input elic_pkg::cfg_reg_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            elic_pkg::CFG_EDGE_MASK:   ext_edge  = value;
            elic_pkg::CFG_ACTIVE_HIGH: ext_high  = value;
            elic_pkg::CFG_LINE_COUNT:  ext_count = value[4:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] edge_m, input logic [15:0] high_m,
                             input logic [4:0] count);
        write_config(elic_pkg::CFG_EDGE_MASK, edge_m);
        write_config(elic_pkg::CFG_ACTIVE_HIGH, high_m);
        write_config(elic_pkg::CFG_LINE_COUNT, {11'd0, count});
        cfg_valid <= 1'b0;
    endtask

    // driver: predicts each accepted transaction and loads the next pending item
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(predict_irq_result(in_data));
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result read_data=%h irq_out=%b", $time,
                             out_data.read_data, out_data.irq_out);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (out_data.read_data !== exp_r.read_data)
                    begin
                        $display("%0t: read_data mismatch: expected %h, actual %h", $time,
                                 exp_r.read_data, out_data.read_data);
                        mismatch_count++;
                    end
                    if (out_data.irq_out !== exp_r.irq_out)
                    begin
                        $display("%0t: irq_out mismatch: expected %b, actual %b", $time,
                                 exp_r.irq_out, out_data.irq_out);
                        mismatch_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        ext_edge   = '0;
        ext_high   = '0;
        ext_count  = '0;
        raw_lines  = '0;
        status_reg = '0;
        enable_reg = '0;
        ack_word   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: even external lines edge, odd level; lines 0,1,4,5 active high
        configure(16'h0055, 16'h0033, 5'd8);
        queue_read(elic_pkg::OFF_STATUS);
        queue_write(elic_pkg::OFF_ENABLE, 32'hffff_ffff);
        queue_read(elic_pkg::OFF_ENABLE);
        queue_line(5'd0, 1'b1);
        queue_line(5'd0, 1'b1);
        queue_line(5'd0, 1'b0);
        queue_read(elic_pkg::OFF_PENDING);
        queue_write(elic_pkg::OFF_ACK, 32'hffff_ffff);
        queue_read(elic_pkg::OFF_ACK);
        queue_line(5'd16, 1'b1);
        queue_line(5'd17, 1'b1);
        // edge bit clears, active level bit comes back
        queue_write(elic_pkg::OFF_ACK, 32'h0003_0000);
        queue_read(elic_pkg::OFF_STATUS);
        queue_line(5'd17, 1'b0);
        queue_line(5'd19, 1'b0);
        queue_line(5'd18, 1'b1);
        queue_line(5'd18, 1'b0);
        queue_line(5'd24, 1'b1);
        queue_line(5'd31, 1'b0);
        queue_write(elic_pkg::OFF_STATUS, 32'hffff_ffff);
        queue_write(elic_pkg::OFF_PENDING, 32'hffff_ffff);
        queue_write(7'h7f, 32'hffff_ffff);
        queue_read(7'h3d);
        pending_items.push_back('{elic_pkg::OP_NOP, 5'h1f, 1'b1, 7'h7f, 32'hffff_ffff});
        queue_write(elic_pkg::OFF_ACK, 32'h0);
        queue_write(elic_pkg::OFF_ENABLE, 32'h0);
        wait_drained();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    configure(16'hffff, 16'hffff, 5'd16);
                    send_idle_pct = 87;
                    stall_pct     = 0;
                end
                1:
                begin
                    configure(16'h0000, 16'h0000, 5'd16);
                    send_idle_pct = 0;
                    stall_pct     = 87;
                end
                2:
                begin
                    configure(16'($urandom), 16'($urandom), 5'($urandom_range(15, 1)));
                    send_idle_pct = 38;
                    stall_pct     = 38;
                end
                3:
                begin
                    // count above the maximum acts as the maximum
                    configure(16'($urandom), 16'($urandom), 5'd31);
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                default:
                begin
                    configure(16'h0000, 16'hffff, 5'd0);
                    send_idle_pct = 38;
                    stall_pct     = 38;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pending_items.push_back(random_irq_item());
                // hold the sender until the block has fully drained
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/elic_pkg.sv
sv/elic_cfg.sv
sv/elic_core.sv
sv/edge_level_interrupt_controller.sv
test/edge_level_interrupt_controller_tb.sv
